// ===== rtl/fedd_pkg.sv =====
`default_nettype none

package fedd_pkg;

  // Field widths
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DEADLINE_W = 33;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned DELTA_W    = 11;  // whole percent times ten, up to 1270
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Cancel band of 2 percent, in tenths of a percent
  localparam logic [DELTA_W-1:0] CANCEL_BAND = 11'd20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_DELTA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELTA   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL   = 8'd3;

  // Configuration reset values
  localparam logic [PCT_W-1:0]   ALARM_DELTA_RST = 7'd10;
  localparam logic [DWELL_W-1:0] DWELL_RST       = 16'd300;
  localparam logic [PCT_W-1:0]   MIN_DELTA_RST   = 7'd0;
  localparam logic [DWELL_W-1:0] MIN_DWELL_RST   = 16'd0;

  // Step outcome codes
  typedef enum logic [2:0] {
    OUT_NONE     = 3'd0,
    OUT_START    = 3'd1,
    OUT_CONTINUE = 3'd2,
    OUT_CANCEL   = 3'd3,
    OUT_CONFIRM  = 3'd4
  } fedd_outcome_t;

  // Effective (clamped) settings handed to the decision logic
  typedef struct packed {
    logic [DELTA_W-1:0] delta_tenths;
    logic [DWELL_W-1:0] dwell;
  } fedd_cfg_t;

  // One result beat
  typedef struct packed {
    fedd_outcome_t      outcome;
    logic [LEVEL_W-1:0] reported_level;
    logic [LEVEL_W-1:0] stable_level_out;
    logic               dwelling;
  } fedd_result_t;

endpackage

`default_nettype wire

// ===== rtl/fedd_if.sv =====
`default_nettype none

// Sample channel
interface fedd_in_if;
  import fedd_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] fuel_level;
  logic [TIME_W-1:0]  now_seconds;

  modport source (output valid, output fuel_level, output now_seconds, input ready);
  modport sink (input valid, input fuel_level, input now_seconds, output ready);
endinterface

// Result channel
interface fedd_out_if;
  import fedd_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         outcome;
  logic [LEVEL_W-1:0] reported_level;
  logic [LEVEL_W-1:0] stable_level_out;
  logic               dwelling;

  modport source (output valid, output outcome, output reported_level,
                  output stable_level_out, output dwelling, input ready);
  modport sink (input valid, input outcome, input reported_level,
                input stable_level_out, input dwelling, output ready);
endinterface

// Configuration write channel
interface fedd_cfg_if;
  import fedd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fedd_cfg.sv =====
`default_nettype none

module fedd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [fedd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [fedd_pkg::CFG_DATA_W-1:0] wr_data,
  output fedd_pkg::fedd_cfg_t                  cfg
);
  import fedd_pkg::*;

  logic [PCT_W-1:0]   alarm_delta_r;
  logic [DWELL_W-1:0] dwell_r;
  logic [PCT_W-1:0]   min_delta_r;
  logic [DWELL_W-1:0] min_dwell_r;
  logic [PCT_W-1:0]   delta_pct;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_delta_r <= ALARM_DELTA_RST;
      dwell_r       <= DWELL_RST;
      min_delta_r   <= MIN_DELTA_RST;
      min_dwell_r   <= MIN_DWELL_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ALARM_DELTA: alarm_delta_r <= wr_data[PCT_W-1:0];
        CFG_DWELL:       dwell_r       <= wr_data;
        CFG_MIN_DELTA:   min_delta_r   <= wr_data[PCT_W-1:0];
        CFG_MIN_DWELL:   min_dwell_r   <= wr_data;
        default: ;
      endcase
    end
  end

  // Clamp to the minimums and scale the delta to tenths (x8 + x2).
  always_comb begin
    delta_pct = (alarm_delta_r < min_delta_r) ? min_delta_r : alarm_delta_r;
    cfg.delta_tenths = {1'b0, delta_pct, 3'b000} + {3'b000, delta_pct, 1'b0};
    cfg.dwell = (dwell_r < min_dwell_r) ? min_dwell_r : dwell_r;
  end

endmodule

`default_nettype wire

// ===== rtl/fedd_core.sv =====
`default_nettype none

module fedd_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [fedd_pkg::LEVEL_W-1:0] level,
  input  wire logic [fedd_pkg::TIME_W-1:0]  now,
  input  wire fedd_pkg::fedd_cfg_t          cfg,
  output fedd_pkg::fedd_result_t            result
);
  import fedd_pkg::*;

  logic                  in_dwell_r, in_dwell_nxt;
  logic [LEVEL_W-1:0]    stable_r, stable_nxt;
  logic [LEVEL_W-1:0]    peak_r, peak_nxt;
  logic [DEADLINE_W-1:0] deadline_r, deadline_nxt;

  logic [DEADLINE_W-1:0] now_ext;
  logic [DEADLINE_W-1:0] fresh_deadline;
  logic                  cancel_drop;
  logic                  rising;
  logic                  start_rise;
  logic                  deadline_hit;
  fedd_outcome_t         outcome;

  // Comparisons that steer the step.
  always_comb begin
    now_ext        = {1'b0, now};
    fresh_deadline = now_ext + {{(DEADLINE_W-DWELL_W){1'b0}}, cfg.dwell};
    cancel_drop    = ({1'b0, level} + CANCEL_BAND) < {1'b0, peak_r};
    rising         = level > peak_r;
    start_rise     = {2'b00, level} >= ({2'b00, stable_r} + {1'b0, cfg.delta_tenths});
    // An unset deadline becomes now plus the dwell, reached only for a zero dwell.
    deadline_hit   = (deadline_r == '0) ? (cfg.dwell == '0) : (now_ext >= deadline_r);
  end

  // Next state and outcome for the sample.
  always_comb begin
    in_dwell_nxt = in_dwell_r;
    stable_nxt   = stable_r;
    peak_nxt     = peak_r;
    deadline_nxt = deadline_r;
    outcome      = OUT_NONE;
    if (in_dwell_r) begin
      if (cancel_drop || (!rising && deadline_hit)) begin
        in_dwell_nxt = 1'b0;
        deadline_nxt = '0;
        stable_nxt   = level;
        peak_nxt     = level;
        outcome      = cancel_drop ? OUT_CANCEL : OUT_CONFIRM;
      end else begin
        outcome = OUT_CONTINUE;
        if (rising) begin
          peak_nxt     = level;
          deadline_nxt = fresh_deadline;
        end else if (deadline_r == '0) begin
          deadline_nxt = fresh_deadline;
        end
      end
    end else if (start_rise) begin
      in_dwell_nxt = 1'b1;
      deadline_nxt = fresh_deadline;
      peak_nxt     = level;
      outcome      = OUT_START;
    end else if (level <= stable_r) begin
      stable_nxt = level;
    end
  end

  // Detector state advances once per processed sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_dwell_r <= 1'b0;
      stable_r   <= '0;
      peak_r     <= '0;
      deadline_r <= '0;
    end else if (step) begin
      in_dwell_r <= in_dwell_nxt;
      stable_r   <= stable_nxt;
      peak_r     <= peak_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  always_comb begin
    result.outcome          = outcome;
    result.reported_level   = level;
    result.stable_level_out = stable_nxt;
    result.dwelling         = in_dwell_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/fill_event_dwell_detector.sv =====
`default_nettype none

// A sample moves from the input register to the result register, which drives its beat.
// Throughput: one sample per cycle while the output takes beats, set by the combinational
// decision logic between the input register and the result register.
// Reset (rst_n, synchronous, active low): both pipeline registers empty, no dwell,
// stable/peak levels and deadline zero, configuration back to 10 pct, 300 s, 0, 0.
module fill_event_dwell_detector (
  input wire logic   clk,
  input wire logic   rst_n,
  fedd_in_if.sink    in_if,
  fedd_out_if.source out_if,
  fedd_cfg_if.sink   cfg_if
);
  import fedd_pkg::*;

  logic               a_valid_r;
  logic [LEVEL_W-1:0] a_level_r;
  logic [TIME_W-1:0]  a_now_r;
  logic               b_valid_r;
  fedd_result_t       b_result_r;
  fedd_result_t       result;
  fedd_cfg_t          cfg;
  logic               advance;
  logic               in_beat;

  // Configuration writes are always taken.
  assign cfg_if.ready = 1'b1;

  fedd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  // Handshake: the input register drains into the result register when that is free.
  assign advance     = a_valid_r && (!b_valid_r || out_if.ready);
  assign in_if.ready = !a_valid_r || advance;
  assign in_beat     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_beat) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      a_level_r <= in_if.fuel_level;
      a_now_r   <= in_if.now_seconds;
    end
  end

  fedd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .level  (a_level_r),
    .now    (a_now_r),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_result_r <= result;
    end
  end

  assign out_if.valid            = b_valid_r;
  assign out_if.outcome          = b_result_r.outcome;
  assign out_if.reported_level   = b_result_r.reported_level;
  assign out_if.stable_level_out = b_result_r.stable_level_out;
  assign out_if.dwelling         = b_result_r.dwelling;

  // A beat that starts or continues a dwell leaves the dwell pending; others do not.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.dwelling ==
      ((out_if.outcome == OUT_START) || (out_if.outcome == OUT_CONTINUE))))
    else $error("dwelling flag disagrees with outcome");

  // Ending a dwell resets the stable level to the sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && ((out_if.outcome == OUT_CANCEL) || (out_if.outcome == OUT_CONFIRM))
      |-> (out_if.stable_level_out == out_if.reported_level))
    else $error("stable level not reset when dwell ended");

  // With no fill under way the stable level never sits above the sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.outcome == OUT_NONE)
      |-> (out_if.stable_level_out <= out_if.reported_level))
    else $error("stable level above sample without dwell");

  // A sample held in the input register is processed or kept, never dropped.
  assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !advance |=> a_valid_r)
    else $error("input register lost a sample");

endmodule

`default_nettype wire
